@@ rtl/core/evt_pkg.sv @@
// shared types and constants for the encoder velocity and turn tracker
// no dependencies
package evt_pkg;

   localparam int BYTE_W      = 8;
   localparam int TIME_W      = 32;
   localparam int ZERO_W      = 12;
   localparam int MIN_W       = 16;
   localparam int MAX_W       = 20;
   localparam int ALPHA_W     = 9;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int VEL_W       = 35;
   localparam int STATUS_W    = 2;
   localparam int SCALE_W     = 28;
   localparam int PROD_W      = VEL_W + ALPHA_W + 1;

   localparam logic [ZERO_W-1:0]  ZERO_OFFSET_RST = 12'd0;
   localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST = 16'd50;
   localparam logic [MAX_W-1:0]   MAX_INTERVAL_RST = 20'd10000;
   localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd51;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   localparam logic [VEL_W-1:0]   VEL_LIMIT = 35'd10485760000;
   localparam logic [SCALE_W-1:0] VEL_SCALE = 28'd256000000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_OFFSET  = 2'd0,
      CSR_MIN_INTERVAL = 2'd1,
      CSR_MAX_INTERVAL = 2'd2,
      CSR_FILTER_ALPHA = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      VST_BASELINE = 2'd0,
      VST_UPDATED  = 2'd1,
      VST_HELD     = 2'd2
   } vel_status_type;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_PREP    = 10'b00_0000_0010,
      ST_NUM     = 10'b00_0000_0100,
      ST_DIV     = 10'b00_0000_1000,
      ST_CLAMP   = 10'b00_0001_0000,
      ST_MUL_NEW = 10'b00_0010_0000,
      ST_MUL_OLD = 10'b00_0100_0000,
      ST_SUM     = 10'b00_1000_0000,
      ST_ROUND   = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/core/evt_if.sv @@
// valid/ready channel interfaces for sample beats and result beats
// depends on evt_pkg
interface evt_req_if;
   logic                        valid;
   logic                        ready;
   logic [evt_pkg::BYTE_W-1:0]  angle_high_byte;
   logic [evt_pkg::BYTE_W-1:0]  angle_low_byte;
   logic [evt_pkg::TIME_W-1:0]  time_us;

   modport source (output valid, output angle_high_byte, output angle_low_byte,
                   output time_us, input ready);
   modport sink   (input valid, input angle_high_byte, input angle_low_byte,
                   input time_us, output ready);
endinterface

interface evt_rsp_if #(
   parameter int ANGLE_BITS = 12,
   parameter int TURN_BITS  = 16
);
   logic                                      valid;
   logic                                      ready;
   logic        [ANGLE_BITS-1:0]              single_turn_angle;
   logic signed [TURN_BITS-1:0]               turn_count;
   logic signed [TURN_BITS+ANGLE_BITS-1:0]    absolute_position;
   logic signed [evt_pkg::VEL_W-1:0]          velocity_q8;
   logic        [evt_pkg::STATUS_W-1:0]       velocity_status;

   modport source (output valid, output single_turn_angle, output turn_count,
                   output absolute_position, output velocity_q8,
                   output velocity_status, input ready);
   modport sink   (input valid, input single_turn_angle, input turn_count,
                   input absolute_position, input velocity_q8,
                   input velocity_status, output ready);
endinterface

@@ rtl/core/evt_div.sv @@
// serial restoring divider, one quotient bit per cycle
// depends on evt_pkg
module evt_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      numerator,
   input  logic [DEN_W-1:0]      denominator,
   output evt_pkg::div_stat_type stat,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numerator;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

@@ rtl/core/encoder_velocity_turn_tracker.sv @@
// Multiturn tracker and velocity estimator for an absolute encoder. Each sample beat
// gives a single-turn angle with the zero offset removed, a saturating turn count, the
// absolute position and an exponentially filtered velocity in counts per second (Q8).
// Steps: a baseline or rejected-interval sample goes from PREP straight to DONE; an
// accepted interval passes NUM, DIV, CLAMP, MUL_NEW, MUL_OLD, SUM and ROUND before DONE,
// with the serial divider producing one quotient bit per cycle over ANGLE_BITS + 28
// bits. One sample is in work at a time; the next can be taken as soon as the result is
// registered, while that result may still wait on rsp_bus.ready.
// Depends on evt_pkg, evt_if and evt_div.
module encoder_velocity_turn_tracker #(
   parameter int ANGLE_BITS = 12,
   parameter int TURN_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   evt_req_if.sink                            req_bus,
   evt_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [evt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [evt_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int NUM_W = ANGLE_BITS + evt_pkg::SCALE_W;
   localparam int POS_W = TURN_BITS + ANGLE_BITS;

   localparam logic        [ANGLE_BITS-1:0] HALF_U  = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [ANGLE_BITS:0]   HALF_S  = {2'b01, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [ANGLE_BITS:0]   NHALF_S = {2'b11, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [TURN_BITS-1:0]  TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0]  TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

   // configuration
   logic [evt_pkg::ZERO_W-1:0]  zero_offset_ff;
   logic [evt_pkg::MIN_W-1:0]   min_interval_ff;
   logic [evt_pkg::MAX_W-1:0]   max_interval_ff;
   logic [evt_pkg::ALPHA_W-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff  <= evt_pkg::ZERO_OFFSET_RST;
         min_interval_ff <= evt_pkg::MIN_INTERVAL_RST;
         max_interval_ff <= evt_pkg::MAX_INTERVAL_RST;
         alpha_ff        <= evt_pkg::ALPHA_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            evt_pkg::CSR_ZERO_OFFSET: begin
               zero_offset_ff <= csr_write_data[evt_pkg::ZERO_W-1:0];
            end
            evt_pkg::CSR_MIN_INTERVAL: begin
               min_interval_ff <= csr_write_data[evt_pkg::MIN_W-1:0];
            end
            evt_pkg::CSR_MAX_INTERVAL: begin
               max_interval_ff <= csr_write_data[evt_pkg::MAX_W-1:0];
            end
            evt_pkg::CSR_FILTER_ALPHA: begin
               alpha_ff <= csr_write_data[evt_pkg::ALPHA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer and working registers
   evt_pkg::seq_state_type  state_ff, state_in;
   evt_pkg::vel_status_type status_ff, status_in;

   logic [ANGLE_BITS-1:0]           raw_ff, raw_in;
   logic [evt_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [ANGLE_BITS-1:0]           angle_ff, angle_in;
   logic [ANGLE_BITS-1:0]           mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [evt_pkg::MAX_W-1:0]       dt_ff, dt_in;
   logic signed [evt_pkg::VEL_W-1:0]  inst_ff, inst_in;
   logic signed [evt_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic signed [evt_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic signed [evt_pkg::PROD_W-1:0] sum_ff, sum_in;

   logic                            primed_ff, primed_in;
   logic [evt_pkg::TIME_W-1:0]      last_time_ff, last_time_in;
   logic [ANGLE_BITS-1:0]           last_raw_ff, last_raw_in;
   logic signed [evt_pkg::VEL_W-1:0]  filtered_ff, filtered_in;
   logic [ANGLE_BITS-1:0]           prev_angle_ff, prev_angle_in;
   logic signed [TURN_BITS-1:0]     turns_ff, turns_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0]           rsp_angle_ff, rsp_angle_in;
   logic signed [TURN_BITS-1:0]     rsp_turns_ff, rsp_turns_in;
   logic signed [evt_pkg::VEL_W-1:0]  rsp_vel_ff, rsp_vel_in;
   evt_pkg::vel_status_type         rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic                            req_beat;
   logic [ANGLE_BITS-1:0]           angle_calc;
   logic signed [ANGLE_BITS:0]      tdiff;
   logic [evt_pkg::TIME_W-1:0]      dt_full;
   logic                            reject;
   logic [ANGLE_BITS-1:0]           ddiff;
   logic                            dneg;
   logic [NUM_W-1:0]                numerator;
   logic [NUM_W-1:0]                quotient;
   evt_pkg::div_stat_type           div_stat;
   logic                            div_start;
   logic [evt_pkg::VEL_W-1:0]       inst_mag;
   logic [evt_pkg::ALPHA_W-1:0]     alpha_sat;
   logic signed [evt_pkg::VEL_W-1:0]  mul_x;
   logic [evt_pkg::ALPHA_W-1:0]     mul_y;
   logic signed [evt_pkg::PROD_W-1:0] mul_p;
   logic signed [evt_pkg::PROD_W-1:0] rounded;

   assign req_beat   = req_bus.valid && req_bus.ready;
   assign angle_calc = raw_ff - ANGLE_BITS'(zero_offset_ff);
   assign tdiff      = $signed({1'b0, angle_calc}) - $signed({1'b0, prev_angle_ff});
   assign dt_full    = now_ff - last_time_ff;
   assign reject     = (dt_full == '0)
                    || (dt_full < {{(evt_pkg::TIME_W-evt_pkg::MIN_W){1'b0}}, min_interval_ff})
                    || (dt_full > {{(evt_pkg::TIME_W-evt_pkg::MAX_W){1'b0}}, max_interval_ff});
   assign ddiff      = raw_ff - last_raw_ff;
   assign dneg       = ddiff > HALF_U;
   assign numerator  = NUM_W'(mag_ff) * NUM_W'(evt_pkg::VEL_SCALE);
   assign div_start  = (state_ff == evt_pkg::ST_NUM);
   assign inst_mag   = (quotient > NUM_W'(evt_pkg::VEL_LIMIT)) ? evt_pkg::VEL_LIMIT
                                                             : quotient[evt_pkg::VEL_W-1:0];
   assign alpha_sat  = (alpha_ff > evt_pkg::ALPHA_ONE) ? evt_pkg::ALPHA_ONE : alpha_ff;

   // shared multiplier for both filter products
   assign mul_x   = (state_ff == evt_pkg::ST_MUL_NEW) ? inst_ff : filtered_ff;
   assign mul_y   = (state_ff == evt_pkg::ST_MUL_NEW) ? alpha_sat : evt_pkg::ALPHA_ONE - alpha_sat;
   assign mul_p   = evt_pkg::PROD_W'(mul_x) * evt_pkg::PROD_W'($signed({1'b0, mul_y}));
   // round to nearest, ties away from zero
   assign rounded = sum_ff + (sum_ff[evt_pkg::PROD_W-1] ? evt_pkg::PROD_W'(127)
                                                         : evt_pkg::PROD_W'(128));

   evt_div #(
      .NUM_W (NUM_W),
      .DEN_W (evt_pkg::MAX_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (numerator),
      .denominator (dt_ff),
      .stat        (div_stat),
      .quotient    (quotient)
   );

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      raw_in        = raw_ff;
      now_in        = now_ff;
      angle_in      = angle_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      dt_in         = dt_ff;
      inst_in       = inst_ff;
      acc_in        = acc_ff;
      mul_in        = mul_ff;
      sum_in        = sum_ff;
      primed_in     = primed_ff;
      last_time_in  = last_time_ff;
      last_raw_in   = last_raw_ff;
      filtered_in   = filtered_ff;
      prev_angle_in = prev_angle_ff;
      turns_in      = turns_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_angle_in  = rsp_angle_ff;
      rsp_turns_in  = rsp_turns_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         evt_pkg::ST_IDLE: begin
            if (req_beat) begin
               raw_in   = ANGLE_BITS'({req_bus.angle_high_byte, req_bus.angle_low_byte});
               now_in   = req_bus.time_us;
               state_in = evt_pkg::ST_PREP;
            end
         end
         evt_pkg::ST_PREP: begin
            angle_in      = angle_calc;
            prev_angle_in = angle_calc;
            if (tdiff > HALF_S) begin
               if (turns_ff != TURN_MIN) begin
                  turns_in = turns_ff - 1'b1;
               end
            end else if (tdiff < NHALF_S) begin
               if (turns_ff != TURN_MAX) begin
                  turns_in = turns_ff + 1'b1;
               end
            end
            if (!primed_ff) begin
               primed_in    = 1'b1;
               last_time_in = now_ff;
               last_raw_in  = raw_ff;
               status_in    = evt_pkg::VST_BASELINE;
               state_in     = evt_pkg::ST_DONE;
            end else if (reject) begin
               status_in = evt_pkg::VST_HELD;
               state_in  = evt_pkg::ST_DONE;
            end else begin
               neg_in   = dneg;
               mag_in   = dneg ? (ANGLE_BITS'(0) - ddiff) : ddiff;
               dt_in    = dt_full[evt_pkg::MAX_W-1:0];
               state_in = evt_pkg::ST_NUM;
            end
         end
         evt_pkg::ST_NUM: begin
            state_in = evt_pkg::ST_DIV;
         end
         evt_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = evt_pkg::ST_CLAMP;
            end
         end
         evt_pkg::ST_CLAMP: begin
            inst_in  = neg_ff ? (evt_pkg::VEL_W'(0) - $signed(inst_mag)) : $signed(inst_mag);
            state_in = evt_pkg::ST_MUL_NEW;
         end
         evt_pkg::ST_MUL_NEW: begin
            acc_in   = mul_p;
            state_in = evt_pkg::ST_MUL_OLD;
         end
         evt_pkg::ST_MUL_OLD: begin
            mul_in   = mul_p;
            state_in = evt_pkg::ST_SUM;
         end
         evt_pkg::ST_SUM: begin
            sum_in   = acc_ff + mul_ff;
            state_in = evt_pkg::ST_ROUND;
         end
         evt_pkg::ST_ROUND: begin
            filtered_in  = rounded[evt_pkg::VEL_W+7:8];
            last_time_in = now_ff;
            last_raw_in  = raw_ff;
            status_in    = evt_pkg::VST_UPDATED;
            state_in     = evt_pkg::ST_DONE;
         end
         evt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_angle_in  = angle_ff;
               rsp_turns_in  = turns_ff;
               rsp_vel_in    = filtered_ff;
               rsp_status_in = status_ff;
               state_in      = evt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      raw_ff        <= raw_in;
      now_ff        <= now_in;
      angle_ff      <= angle_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      dt_ff         <= dt_in;
      inst_ff       <= inst_in;
      acc_ff        <= acc_in;
      mul_ff        <= mul_in;
      sum_ff        <= sum_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_turns_ff  <= rsp_turns_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff      <= evt_pkg::ST_IDLE;
         primed_ff     <= 1'b0;
         last_time_ff  <= '0;
         last_raw_ff   <= '0;
         filtered_ff   <= '0;
         prev_angle_ff <= '0;
         turns_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         primed_ff     <= primed_in;
         last_time_ff  <= last_time_in;
         last_raw_ff   <= last_raw_in;
         filtered_ff   <= filtered_in;
         prev_angle_ff <= prev_angle_in;
         turns_ff      <= turns_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_bus.ready             = (state_ff == evt_pkg::ST_IDLE);
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.single_turn_angle = rsp_angle_ff;
   assign rsp_bus.turn_count        = rsp_turns_ff;
   assign rsp_bus.absolute_position = POS_W'({rsp_turns_ff, rsp_angle_ff});
   assign rsp_bus.velocity_q8       = rsp_vel_ff;
   assign rsp_bus.velocity_status   = rsp_status_ff;

   // divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == evt_pkg::ST_DIV)
      else $error("divider busy outside divide state");

   // filtered velocity stays inside the saturation band
   a_vel_bound: assert property (@(posedge clock) disable iff (reset)
      (filtered_ff <= $signed(evt_pkg::VEL_LIMIT))
      && (filtered_ff >= -$signed(evt_pkg::VEL_LIMIT)))
      else $error("filtered velocity out of range");

   // turn count moves only while a sample is being prepared
   a_turns_prep: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (turns_ff != $past(turns_ff)))
      |-> $past(state_ff) == evt_pkg::ST_PREP)
      else $error("turn count changed outside sample preparation");

endmodule
